// ===== rtl/ghn_pkg.sv =====
// Package for the gray histogram normaliser.
// Holds sizes, register indexes, controller/datapath command and status
// structs and the count saturation helper. No dependencies.
package ghn_pkg;

    localparam int NUM_BINS   = 256;
    localparam int COUNT_BITS = 21;
    localparam int BIN_W      = $clog2(NUM_BINS);

    localparam int PIX_W      = 8;
    localparam int ROWS_W     = 13;
    localparam int OUT_CNT_W  = 21;
    localparam int OUT_SCL_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Product of count and rows, and the divider's quotient width
    localparam int PROD_W     = COUNT_BITS + ROWS_W;
    localparam int QUO_W      = OUT_SCL_W;
    localparam int STEP_W     = $clog2(QUO_W);

    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

    localparam logic [PIX_W-1:0]  THRESHOLD_RESET = PIX_W'(60);
    localparam logic [ROWS_W-1:0] ROWS_RESET      = ROWS_W'(256);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROWS      = CFG_IDX_W'(1);

    // Item opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic accept;   // latch the item and issue the bin read
        logic update;   // count a pixel and form its result
        logic mul;      // form a read result and start the divide
        logic push;     // move the pending result to the output register
    } t_cmd;

    typedef struct packed {
        logic peak_zero;
        logic div_done;
        logic out_free;
    } t_status;

    // Clamp a count to the output field's full scale
    function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
        logic [OUT_CNT_W-1:0] r;
        if (64'(c) > ((64'd1 << OUT_CNT_W) - 64'd1)) begin
            r = '1;
        end else begin
            r = OUT_CNT_W'(c);
        end
        return r;
    endfunction

endpackage

// ===== rtl/ghn_divider.sv =====
// Restoring divider for the bin scaling, one quotient bit per cycle.
// Depends on ghn_pkg. The quotient is known to fit QUO_W bits since a
// bin count never exceeds the peak and rows fit QUO_W bits.
module ghn_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ghn_pkg::PROD_W-1:0]     i_dividend,
    input  logic [ghn_pkg::COUNT_BITS-1:0] i_divisor,
    output logic                           o_done,
    output logic [ghn_pkg::QUO_W-1:0]      o_quotient
);

    logic                           r_busy;
    logic [ghn_pkg::STEP_W-1:0]     r_step;
    logic [ghn_pkg::COUNT_BITS-1:0] r_rem;
    logic [ghn_pkg::COUNT_BITS-1:0] r_div;
    logic [ghn_pkg::QUO_W-1:0]      r_low;
    logic [ghn_pkg::QUO_W-1:0]      r_quo;
    logic                           r_done;

    logic [ghn_pkg::COUNT_BITS:0]   trial;
    logic                           fits;
    logic                           last;

    // Shift in the next dividend bit and test against the divisor
    assign trial = {r_rem, r_low[ghn_pkg::QUO_W-1]};
    assign fits  = trial >= {1'b0, r_div};
    assign last  = r_step == ghn_pkg::STEP_W'(ghn_pkg::QUO_W - 1);

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[ghn_pkg::PROD_W-1:ghn_pkg::QUO_W];
            r_low <= i_dividend[ghn_pkg::QUO_W-1:0];
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? ghn_pkg::COUNT_BITS'(trial - {1'b0, r_div})
                          : ghn_pkg::COUNT_BITS'(trial);
            r_low <= {r_low[ghn_pkg::QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[ghn_pkg::QUO_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/ghn_datapath.sv =====
// Datapath: histogram memory with valid bits, peak tracking, thresholding,
// scaling multiply and divide, config registers and the output register.
// Depends on ghn_pkg and ghn_divider.
module ghn_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ghn_pkg::t_cmd                   i_cmd,
    output ghn_pkg::t_status                o_status,
    input  logic                            i_opcode,
    input  logic [ghn_pkg::PIX_W-1:0]       i_pixel_value,
    input  logic [ghn_pkg::PIX_W-1:0]       i_bin_index,
    input  logic                            i_cfg_we,
    input  logic [ghn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ghn_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic [ghn_pkg::PIX_W-1:0]       o_pixel_out,
    output logic [ghn_pkg::OUT_CNT_W-1:0]   o_bin_count,
    output logic [ghn_pkg::OUT_SCL_W-1:0]   o_bin_scaled,
    output logic                            o_empty_flag
);

    logic [ghn_pkg::COUNT_BITS-1:0] r_mem [ghn_pkg::NUM_BINS];
    logic [ghn_pkg::NUM_BINS-1:0]   r_vld;
    logic [ghn_pkg::COUNT_BITS-1:0] r_peak;
    logic [ghn_pkg::PIX_W-1:0]      r_threshold;
    logic [ghn_pkg::ROWS_W-1:0]     r_rows;

    logic [ghn_pkg::BIN_W-1:0]      r_bin;
    logic                           r_oob;
    logic [ghn_pkg::PIX_W-1:0]      r_pix;
    logic [ghn_pkg::COUNT_BITS-1:0] r_rd_data;
    logic                           r_rd_vld;

    logic [ghn_pkg::PIX_W-1:0]      r_pix_res;
    logic [ghn_pkg::OUT_CNT_W-1:0]  r_cnt_res;
    logic [ghn_pkg::OUT_SCL_W-1:0]  r_scl_res;
    logic                           r_empty_res;

    logic                           r_out_valid;
    logic [ghn_pkg::PIX_W-1:0]      r_out_pix;
    logic [ghn_pkg::OUT_CNT_W-1:0]  r_out_cnt;
    logic [ghn_pkg::OUT_SCL_W-1:0]  r_out_scl;
    logic                           r_out_empty;

    logic [ghn_pkg::BIN_W-1:0]      rd_addr;
    logic                           rd_oob;
    logic [ghn_pkg::COUNT_BITS-1:0] cur;
    logic [ghn_pkg::COUNT_BITS-1:0] inc;
    logic [ghn_pkg::COUNT_BITS-1:0] n_peak;
    logic [ghn_pkg::PROD_W-1:0]     prod;
    logic                           div_start;
    logic                           div_done;
    logic [ghn_pkg::QUO_W-1:0]      quotient;

    // Bin address: pixels clamp into the last bin, reads past the end miss
    always_comb begin
        rd_oob = 1'b0;
        if (i_opcode == ghn_pkg::OP_READ) begin
            rd_oob  = 32'(i_bin_index) >= ghn_pkg::NUM_BINS;
            rd_addr = ghn_pkg::BIN_W'(i_bin_index);
        end else if (32'(i_pixel_value) >= ghn_pkg::NUM_BINS) begin
            rd_addr = ghn_pkg::BIN_W'(ghn_pkg::NUM_BINS - 1);
        end else begin
            rd_addr = ghn_pkg::BIN_W'(i_pixel_value);
        end
    end

    // Count of the addressed bin, saturating increment and new peak
    assign cur    = (r_rd_vld && !r_oob) ? r_rd_data : '0;
    assign inc    = (cur == ghn_pkg::COUNT_FULL) ? cur : cur + 1'b1;
    assign n_peak = (inc > r_peak) ? inc : r_peak;
    assign prod   = ghn_pkg::PROD_W'(cur) * ghn_pkg::PROD_W'(r_rows);

    assign div_start = i_cmd.mul && (r_peak != '0);

    ghn_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod),
        .i_divisor  (r_peak),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Histogram memory: read on accept, write back on update
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_cmd.update) begin
            r_mem[r_bin] <= inc;
        end
    end

    // Valid bits, peak, config and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_peak      <= '0;
            r_threshold <= ghn_pkg::THRESHOLD_RESET;
            r_rows      <= ghn_pkg::ROWS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_vld[r_bin] <= 1'b1;
                r_peak       <= n_peak;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ghn_pkg::REG_THRESHOLD: r_threshold <= ghn_pkg::PIX_W'(i_cfg_data);
                    ghn_pkg::REG_ROWS:      r_rows      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item latch, pending result and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_bin    <= rd_addr;
            r_oob    <= rd_oob;
            r_pix    <= i_pixel_value;
            r_rd_vld <= r_vld[rd_addr];
        end
        if (i_cmd.update) begin
            r_pix_res   <= (r_pix < r_threshold) ? '0 : r_pix;
            r_cnt_res   <= '0;
            r_scl_res   <= '0;
            r_empty_res <= n_peak == '0;
        end
        if (i_cmd.mul) begin
            r_pix_res   <= '0;
            r_cnt_res   <= ghn_pkg::sat_count(cur);
            r_scl_res   <= '0;
            r_empty_res <= r_peak == '0;
        end
        if (div_done) begin
            r_scl_res <= quotient;
        end
        if (i_cmd.push) begin
            r_out_pix   <= r_pix_res;
            r_out_cnt   <= r_cnt_res;
            r_out_scl   <= r_scl_res;
            r_out_empty <= r_empty_res;
        end
    end

    assign o_status.peak_zero = r_peak == '0;
    assign o_status.div_done  = div_done;
    assign o_status.out_free  = !r_out_valid || i_ready;

    assign o_valid      = r_out_valid;
    assign o_pixel_out  = r_out_pix;
    assign o_bin_count  = r_out_cnt;
    assign o_bin_scaled = r_out_scl;
    assign o_empty_flag = r_out_empty;

endmodule

// ===== rtl/ghn_ctrl.sv =====
// Controller state machine for the histogram normaliser.
// Depends on ghn_pkg; drives the datapath by t_cmd and reads t_status.
module ghn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_opcode,
    output logic             o_ready,
    input  ghn_pkg::t_status i_status,
    output ghn_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UPD  = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_opcode == ghn_pkg::OP_READ) ? S_MUL : S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_PUSH;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = i_status.peak_zero ? S_PUSH : S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold or advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/gray_histogram_normalizer_core.sv =====
// Top level of the gray histogram normaliser.
// Depends on ghn_pkg, ghn_ctrl, ghn_datapath (and ghn_divider beneath it).
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  in       | i_valid / o_ready  | i_opcode, i_pixel_value, i_bin_index
//  out      | o_valid / i_ready  | o_pixel_out, o_bin_count, o_bin_scaled, o_empty_flag
//  config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// A pixel item steps through accept with bin read, count update and result push.
// A read item steps through accept with bin read and the multiply to the push, with an
// empty histogram directly, else via the divider at one quotient bit per cycle.
// Reset is synchronous; the 256 bin valid bits clear at once, so items are
// taken from the first cycle after reset. A stalled output holds the next
// item in the push step until the output register frees.
module gray_histogram_normalizer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_opcode,
    input  logic [ghn_pkg::PIX_W-1:0]       i_pixel_value,
    input  logic [ghn_pkg::PIX_W-1:0]       i_bin_index,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ghn_pkg::PIX_W-1:0]       o_pixel_out,
    output logic [ghn_pkg::OUT_CNT_W-1:0]   o_bin_count,
    output logic [ghn_pkg::OUT_SCL_W-1:0]   o_bin_scaled,
    output logic                            o_empty_flag,
    input  logic                            i_cfg_we,
    input  logic [ghn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ghn_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ghn_pkg::t_cmd    cmd;
    ghn_pkg::t_status status;

    ghn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ghn_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_opcode      (i_opcode),
        .i_pixel_value (i_pixel_value),
        .i_bin_index   (i_bin_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_pixel_out   (o_pixel_out),
        .o_bin_count   (o_bin_count),
        .o_bin_scaled  (o_bin_scaled),
        .o_empty_flag  (o_empty_flag)
    );

endmodule

// ===== rtl/ghn_checker.sv =====
// Port-level checks for the gray histogram normaliser, bound to the top level.
// Depends on ghn_pkg and gray_histogram_normalizer_core.
module ghn_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [ghn_pkg::PIX_W-1:0]       o_pixel_out,
    input logic [ghn_pkg::OUT_CNT_W-1:0]   o_bin_count,
    input logic [ghn_pkg::OUT_SCL_W-1:0]   o_bin_scaled,
    input logic                            o_empty_flag
);

    // One item at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while an item is in progress");

    // An empty histogram scales to zero
    a_empty_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_flag) |-> (o_bin_scaled == '0))
        else $error("scaled value nonzero with empty histogram");

    // A zero count scales to zero
    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_bin_count == '0)) |-> (o_bin_scaled == '0))
        else $error("scaled value nonzero for empty bin");

    // A passed pixel comes from a counted pixel, so a zero bin count and not empty
    a_pixel_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_pixel_out != '0)) |->
        ((o_bin_count == '0) && !o_empty_flag))
        else $error("pixel result carries read fields or empty flag");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_bin_count)
        && $stable(o_bin_scaled) && $stable(o_pixel_out)))
        else $error("stalled result changed");

endmodule

bind gray_histogram_normalizer_core ghn_checker u_ghn_checker (.*);

// ===== tb/gray_histogram_normalizer_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gray_histogram_normalizer_core: pixel counting,
// thresholding and scaled bin reads against an in-bench histogram predictor.
// Depends on ghn_pkg and the core RTL only.
module gray_histogram_normalizer_core_test;

    // Register indexes with no register behind them
    localparam logic [ghn_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = ghn_pkg::CFG_IDX_W'(2);
    localparam logic [ghn_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = ghn_pkg::CFG_IDX_W'(3);

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 40;
    localparam int IDLE_PERCENT = 21;

    typedef struct packed {
        logic [ghn_pkg::PIX_W-1:0]     pixel_out;
        logic [ghn_pkg::OUT_CNT_W-1:0] bin_count;
        logic [ghn_pkg::OUT_SCL_W-1:0] bin_scaled;
        logic                          empty_flag;
    } t_hist_result;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_valid = 1'b0;
    logic                                 o_ready;
    logic                                 i_opcode = ghn_pkg::OP_PIXEL;
    logic [ghn_pkg::PIX_W-1:0]            i_pixel_value = '0;
    logic [ghn_pkg::PIX_W-1:0]            i_bin_index = '0;
    logic                                 o_valid;
    logic                                 i_ready = 1'b0;
    logic [ghn_pkg::PIX_W-1:0]            o_pixel_out;
    logic [ghn_pkg::OUT_CNT_W-1:0]        o_bin_count;
    logic [ghn_pkg::OUT_SCL_W-1:0]        o_bin_scaled;
    logic                                 o_empty_flag;
    logic                                 i_cfg_we = 1'b0;
    logic [ghn_pkg::CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [ghn_pkg::CFG_DATA_W-1:0]       i_cfg_data = '0;

    // Predicted block state
    logic [ghn_pkg::COUNT_BITS-1:0]       hist_bins [ghn_pkg::NUM_BINS];
    logic [ghn_pkg::COUNT_BITS-1:0]       hist_peak;
    logic [ghn_pkg::PIX_W-1:0]            cfg_threshold;
    logic [ghn_pkg::ROWS_W-1:0]           cfg_rows;

    t_hist_result                         awaited_results [$];
    int                                   fail_count = 0;
    bit                                   idle_on = 1'b1;
    bit                                   stall_request = 1'b0;
    int                                   stall_left = 0;
    logic [ghn_pkg::PIX_W-1:0]            hot_pixel = '0;

    gray_histogram_normalizer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_pixel_value (i_pixel_value),
        .i_bin_index   (i_bin_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_out   (o_pixel_out),
        .o_bin_count   (o_bin_count),
        .o_bin_scaled  (o_bin_scaled),
        .o_empty_flag  (o_empty_flag),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Count or read one item in the predicted histogram and form its result
    function automatic t_hist_result hist_predict(input logic op,
                                                  input logic [ghn_pkg::PIX_W-1:0] pix,
                                                  input logic [ghn_pkg::PIX_W-1:0] idx);
        t_hist_result                   r;
        int                             b;
        logic [ghn_pkg::COUNT_BITS-1:0] c;
        logic [ghn_pkg::PROD_W-1:0]     q;
        r = '0;
        if (op == ghn_pkg::OP_PIXEL) begin
            b = int'(pix);
            if (b >= ghn_pkg::NUM_BINS) begin
                b = ghn_pkg::NUM_BINS - 1;
            end
            if (hist_bins[b] != ghn_pkg::COUNT_FULL) begin
                hist_bins[b] = hist_bins[b] + 1'b1;
            end
            if (hist_bins[b] > hist_peak) begin
                hist_peak = hist_bins[b];
            end
            r.pixel_out = (pix < cfg_threshold) ? '0 : pix;
        end else begin
            c = (int'(idx) < ghn_pkg::NUM_BINS) ? hist_bins[idx] : '0;
            r.bin_count = (64'(c) > 64'(2**ghn_pkg::OUT_CNT_W - 1)) ? '1
                          : ghn_pkg::OUT_CNT_W'(c);
            if (hist_peak != '0) begin
                q = (ghn_pkg::PROD_W'(c) * ghn_pkg::PROD_W'(cfg_rows))
                    / ghn_pkg::PROD_W'(hist_peak);
                r.bin_scaled = (q > ghn_pkg::PROD_W'(2**ghn_pkg::OUT_SCL_W - 1)) ? '1
                               : ghn_pkg::OUT_SCL_W'(q);
            end
        end
        r.empty_flag = (hist_peak == '0);
        return r;
    endfunction

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (stall_request) begin
            stall_left = HOLD_CYCLES;
            stall_request = 1'b0;
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(idle_on && ($urandom_range(99) < IDLE_PERCENT));
        end
    end

    // Compare each accepted result with the oldest awaited one
    always @(posedge i_clk) begin : check_results
        t_hist_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result with none awaited: pixel_out %0d bin_count %0d bin_scaled %0d",
                       o_pixel_out, o_bin_count, o_bin_scaled);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_pixel_out !== want.pixel_out) begin
                    $error("pixel_out: expected %0d, got %0d", want.pixel_out, o_pixel_out);
                    fail_count++;
                end
                if (o_bin_count !== want.bin_count) begin
                    $error("bin_count: expected %0d, got %0d", want.bin_count, o_bin_count);
                    fail_count++;
                end
                if (o_bin_scaled !== want.bin_scaled) begin
                    $error("bin_scaled: expected %0d, got %0d", want.bin_scaled, o_bin_scaled);
                    fail_count++;
                end
                if (o_empty_flag !== want.empty_flag) begin
                    $error("empty_flag: expected %0d, got %0d", want.empty_flag, o_empty_flag);
                    fail_count++;
                end
            end
        end
    end

    // Offer one item from a falling edge; return at the falling edge after acceptance
    task automatic send_item(input logic op, input logic [ghn_pkg::PIX_W-1:0] pix,
                             input logic [ghn_pkg::PIX_W-1:0] idx);
        int gap;
        gap = 0;
        while (idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
            gap++;
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_pixel_value <= pix;
        i_bin_index   <= idx;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        awaited_results.push_back(hist_predict(op, pix, idx));
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every awaited result has come
    task automatic settle();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [ghn_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ghn_pkg::CFG_DATA_W-1:0] data);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == ghn_pkg::REG_THRESHOLD) begin
            cfg_threshold = data[ghn_pkg::PIX_W-1:0];
        end else if (idx == ghn_pkg::REG_ROWS) begin
            cfg_rows = data;
        end
    endtask

    // Pixels cluster round a hot value so that the peak moves; reads favour it too
    task automatic send_random_item();
        logic                      op;
        logic [ghn_pkg::PIX_W-1:0] pix;
        logic [ghn_pkg::PIX_W-1:0] idx;
        op  = ($urandom_range(99) < 15) ? ghn_pkg::OP_READ : ghn_pkg::OP_PIXEL;
        pix = ($urandom_range(1) == 0) ? ghn_pkg::PIX_W'($urandom)
              : hot_pixel + ghn_pkg::PIX_W'($urandom_range(3));
        idx = ($urandom_range(9) < 7) ? ghn_pkg::PIX_W'($urandom)
              : hot_pixel + ghn_pkg::PIX_W'($urandom_range(3));
        send_item(op, pix, idx);
    endtask

    task automatic run_random_phase(input int count, input logic [ghn_pkg::PIX_W-1:0] thr,
                                    input logic [ghn_pkg::ROWS_W-1:0] rows, input bit idle);
        write_reg(ghn_pkg::REG_THRESHOLD, {5'($urandom), thr});
        write_reg(ghn_pkg::REG_ROWS, rows);
        write_reg(($urandom_range(1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                  ghn_pkg::CFG_DATA_W'($urandom));
        hot_pixel = ghn_pkg::PIX_W'($urandom);
        idle_on   = idle;
        repeat (count) send_random_item();
        settle();
        idle_on = 1'b1;
    endtask

    // Reads of the cleared histogram
    task automatic test_empty_reads();
        send_item(ghn_pkg::OP_READ, 8'h00, 8'd0);
        send_item(ghn_pkg::OP_READ, 8'hFF, 8'd255);
    endtask

    // Pixels either side of the threshold at reset, lowest and highest settings
    task automatic test_threshold_edges();
        send_item(ghn_pkg::OP_PIXEL, 8'd0, 8'hFF);
        send_item(ghn_pkg::OP_PIXEL, 8'd59, 8'h00);
        send_item(ghn_pkg::OP_PIXEL, 8'd60, 8'h00);
        send_item(ghn_pkg::OP_PIXEL, 8'd255, 8'h00);
        send_item(ghn_pkg::OP_PIXEL, 8'd255, 8'h00);
        write_reg(ghn_pkg::REG_THRESHOLD, 13'h1F00);
        send_item(ghn_pkg::OP_PIXEL, 8'd0, 8'h00);
        send_item(ghn_pkg::OP_PIXEL, 8'd1, 8'h00);
        write_reg(ghn_pkg::REG_THRESHOLD, 13'h00FF);
        send_item(ghn_pkg::OP_PIXEL, 8'd254, 8'h00);
        send_item(ghn_pkg::OP_PIXEL, 8'd255, 8'h00);
    endtask

    // Peak, partial and empty bins, first and last bin included
    task automatic test_bin_reads();
        send_item(ghn_pkg::OP_READ, 8'h00, 8'd255);
        send_item(ghn_pkg::OP_READ, 8'h00, 8'd0);
        send_item(ghn_pkg::OP_READ, 8'h00, 8'd60);
        send_item(ghn_pkg::OP_READ, 8'h00, 8'd128);
    endtask

    // Zero rows, full 13-bit rows and a single row
    task automatic test_rows_edges();
        write_reg(ghn_pkg::REG_ROWS, 13'd0);
        send_item(ghn_pkg::OP_READ, 8'h00, 8'd255);
        write_reg(ghn_pkg::REG_ROWS, 13'h1FFF);
        send_item(ghn_pkg::OP_READ, 8'h00, 8'd255);
        send_item(ghn_pkg::OP_READ, 8'h00, 8'd0);
        write_reg(ghn_pkg::REG_ROWS, 13'd1);
        send_item(ghn_pkg::OP_READ, 8'h00, 8'd255);
        send_item(ghn_pkg::OP_READ, 8'h00, 8'd59);
    endtask

    // Writes to the spare indexes must leave both registers alone
    task automatic test_unknown_registers();
        write_reg(REG_SPARE_2, 13'h1FFF);
        write_reg(REG_SPARE_3, 13'h0000);
        send_item(ghn_pkg::OP_READ, 8'h00, 8'd255);
        send_item(ghn_pkg::OP_PIXEL, 8'd30, 8'h00);
        write_reg(ghn_pkg::REG_THRESHOLD, 13'd60);
        write_reg(ghn_pkg::REG_ROWS, 13'd256);
    endtask

    // Random traffic over several settings, one phase with no idling
    task automatic test_random_traffic();
        run_random_phase(190, ghn_pkg::PIX_W'($urandom),
                         ghn_pkg::ROWS_W'($urandom_range(4096, 1)), 1'b1);
        run_random_phase(190, 8'd0, 13'h1FFF, 1'b1);
        run_random_phase(190, 8'd255, 13'd1, 1'b0);
        run_random_phase(190, ghn_pkg::PIX_W'($urandom), 13'd0, 1'b1);
        run_random_phase(190, ghn_pkg::PIX_W'($urandom), ghn_pkg::ROWS_W'($urandom), 1'b1);
    endtask

    // Hold the output off while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        write_reg(ghn_pkg::REG_ROWS, 13'd4096);
        stall_request = 1'b1;
        repeat (40) send_random_item();
        settle();
    endtask

    // Stop sending until everything is back, then carry on
    task automatic test_sender_pause();
        repeat (25) send_random_item();
        settle();
        repeat (25) send_random_item();
    endtask

    initial begin : run_tests
        int waited;
        for (int i = 0; i < ghn_pkg::NUM_BINS; i++) begin
            hist_bins[i] = '0;
        end
        hist_peak     = '0;
        cfg_threshold = ghn_pkg::THRESHOLD_RESET;
        cfg_rows      = ghn_pkg::ROWS_RESET;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_reads();
        test_threshold_edges();
        test_bin_reads();
        test_rows_edges();
        test_unknown_registers();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();

        // Drain with a bound, then let the tail run out
        i_valid <= 1'b0;
        waited = 0;
        while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (awaited_results.size() != 0) begin
            $error("%0d results never arrived", awaited_results.size());
            fail_count += awaited_results.size();
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("gray_histogram_normalizer_core test passed");
        end else begin
            $display("gray_histogram_normalizer_core test failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #5000000;
        $display("gray_histogram_normalizer_core test failed");
        $finish;
    end

endmodule
